// ----- src/lbr_pkg.sv -----
// lbr_pkg: shared types and constants for the LSB-first bit reader.
// Request/result payload structs, item kinds and default parameter values.
// No dependencies.
`timescale 1ns / 1ps

package lbr_pkg;

    localparam int LBR_STORE_BYTES = 4096;
    localparam int LBR_MAX_BITS    = 24;
    localparam int LBR_POS_W       = 13;

    typedef enum logic [3:0] {
        KIND_LOAD       = 4'd0,
        KIND_RESTART    = 4'd1,
        KIND_SEEK       = 4'd2,
        KIND_SKIP       = 4'd3,
        KIND_U16        = 4'd4,
        KIND_U32        = 4'd5,
        KIND_READ_BYTES = 4'd6,
        KIND_BITS       = 4'd7,
        KIND_BITS_BASE  = 4'd8,
        KIND_ALIGN      = 4'd9
    } t_kind;

    typedef struct packed {
        logic [3:0]           kind;
        logic [11:0]          load_address;
        logic [7:0]           load_byte;
        logic [LBR_POS_W-1:0] target_position;
        logic [LBR_POS_W-1:0] byte_count;
        logic [4:0]           bit_count;
        logic [31:0]          base_value;
    } t_req;

    typedef struct packed {
        logic [31:0]          value;
        logic                 error;
        logic [LBR_POS_W-1:0] position;
    } t_res;

endpackage

// ----- src/lbr_store.sv -----
// lbr_store: byte store, one write port and one read port, registered read data.
// Depends on lbr_pkg for the default depth.
`timescale 1ns / 1ps

module lbr_store
    import lbr_pkg::*;
#(
    parameter int STORE_BYTES = LBR_STORE_BYTES,
    parameter int AW          = $clog2(STORE_BYTES)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [STORE_BYTES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/lbr_ctrl.sv -----
// lbr_ctrl: request sequencer of the bit reader; position, bit buffer, error flag,
// byte fetch engine and result register. Depends on lbr_pkg; drives lbr_store.
`timescale 1ns / 1ps

module lbr_ctrl
    import lbr_pkg::*;
#(
    parameter int STORE_BYTES = LBR_STORE_BYTES,
    parameter int MAX_BITS    = LBR_MAX_BITS,
    parameter int AW          = $clog2(STORE_BYTES)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  t_req                 i_req,
    input  logic [LBR_POS_W-1:0] i_stream_size,
    input  logic [7:0]           i_rdata,
    output logic                 o_busy,
    output logic                 o_res_valid,
    output t_res                 o_res,
    output logic                 o_we,
    output logic [AW-1:0]        o_waddr,
    output logic [7:0]           o_wdata,
    output logic                 o_re,
    output logic [AW-1:0]        o_raddr
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_FINISH
    } t_state;

    t_state               r_state, n_state;
    logic [LBR_POS_W-1:0] r_pos, n_pos;
    logic [31:0]          r_buf, n_buf;
    logic [5:0]           r_bb, n_bb;
    logic                 r_err, n_err;
    logic [3:0]           r_kind, n_kind;
    logic [4:0]           r_n, n_n;
    logic [31:0]          r_base, n_base;
    logic [31:0]          r_acc, n_acc;
    logic [5:0]           r_sh, n_sh;
    logic [LBR_POS_W-1:0] r_addr, n_addr;
    logic [2:0]           r_issue_left, n_issue_left;
    logic [2:0]           r_rx_left, n_rx_left;
    logic                 r_pend, n_pend;
    logic                 r_res_valid, n_res_valid;
    t_res                 r_res, n_res;

    logic                 accept;
    logic [4:0]           nbits_sat;
    logic [5:0]           bit_diff;
    logic [2:0]           need;
    logic [LBR_POS_W-1:0] avail;
    logic [LBR_POS_W:0]   sum_cnt;
    logic [LBR_POS_W:0]   sum_word;
    logic [2:0]           word_bytes;
    logic [2:0]           align_k;
    logic [31:0]          take_mask;
    logic [31:0]          take_v;

    assign accept    = i_start && (r_state == S_IDLE);
    assign o_busy    = (r_state != S_IDLE);
    assign nbits_sat = (i_req.bit_count > 5'(MAX_BITS)) ? 5'(MAX_BITS) : i_req.bit_count;
    assign bit_diff  = {1'b0, nbits_sat} - r_bb;
    assign need      = ({1'b0, nbits_sat} > r_bb) ? 3'((bit_diff + 6'd7) >> 3) : 3'd0;
    assign avail     = (i_stream_size > r_pos) ? (i_stream_size - r_pos) : '0;
    assign sum_cnt   = {1'b0, r_pos} + {1'b0, i_req.byte_count};
    assign word_bytes = (i_req.kind == KIND_U32) ? 3'd4 : 3'd2;
    assign sum_word  = {1'b0, r_pos} + (LBR_POS_W+1)'(word_bytes);
    assign align_k   = r_bb[5:3];
    assign take_mask = (32'd1 << r_n) - 32'd1;
    assign take_v    = r_acc & take_mask;

    always_comb begin
        n_state      = r_state;
        n_pos        = r_pos;
        n_buf        = r_buf;
        n_bb         = r_bb;
        n_err        = r_err;
        n_kind       = r_kind;
        n_n          = r_n;
        n_base       = r_base;
        n_acc        = r_acc;
        n_sh         = r_sh;
        n_addr       = r_addr;
        n_issue_left = r_issue_left;
        n_rx_left    = r_rx_left;
        n_pend       = 1'b0;
        n_res_valid  = 1'b0;
        n_res        = r_res;
        o_we         = 1'b0;
        o_waddr      = AW'(i_req.load_address);
        o_wdata      = i_req.load_byte;
        o_re         = 1'b0;
        o_raddr      = AW'(r_pos);

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_kind     = i_req.kind;
                    n_n        = nbits_sat;
                    n_base     = i_req.base_value;
                    // default: answer right away with the updated state
                    n_res_valid = 1'b1;
                    n_res.value = '0;
                    if (i_req.kind == KIND_LOAD) begin
                        o_we = (32'(i_req.load_address) < 32'(STORE_BYTES));
                    end else if (i_req.kind == KIND_RESTART) begin
                        n_pos = '0;
                        n_buf = '0;
                        n_bb  = '0;
                        n_err = 1'b0;
                    end else if (!r_err) begin
                        case (i_req.kind)
                            KIND_SEEK: begin
                                if (i_req.target_position > i_stream_size) begin
                                    n_err = 1'b1;
                                end else begin
                                    n_pos = i_req.target_position;
                                    n_buf = '0;
                                    n_bb  = '0;
                                end
                            end
                            KIND_SKIP, KIND_READ_BYTES: begin
                                if (sum_cnt > {1'b0, i_stream_size}) begin
                                    n_err = 1'b1;
                                end else begin
                                    if (i_req.kind == KIND_READ_BYTES) begin
                                        n_res.value = 32'(r_pos);
                                    end
                                    n_pos = sum_cnt[LBR_POS_W-1:0];
                                end
                            end
                            KIND_U16, KIND_U32: begin
                                if (sum_word > {1'b0, i_stream_size}) begin
                                    n_err = 1'b1;
                                end else begin
                                    n_res_valid  = 1'b0;
                                    n_acc        = '0;
                                    n_sh         = '0;
                                    o_re         = 1'b1;
                                    n_pend       = 1'b1;
                                    n_addr       = r_pos + 1'b1;
                                    n_issue_left = word_bytes - 3'd1;
                                    n_rx_left    = word_bytes;
                                    n_pos        = sum_word[LBR_POS_W-1:0];
                                    n_state      = S_FETCH;
                                end
                            end
                            KIND_BITS, KIND_BITS_BASE: begin
                                if (LBR_POS_W'(need) > avail) begin
                                    // partial refill: the bytes that exist are consumed
                                    n_pos = r_pos + avail;
                                    n_err = 1'b1;
                                end else begin
                                    n_res_valid = 1'b0;
                                    n_acc       = r_buf;
                                    n_sh        = r_bb;
                                    if (need == 3'd0) begin
                                        n_state = S_FINISH;
                                    end else begin
                                        o_re         = 1'b1;
                                        n_pend       = 1'b1;
                                        n_addr       = r_pos + 1'b1;
                                        n_issue_left = need - 3'd1;
                                        n_rx_left    = need;
                                        n_pos        = r_pos + LBR_POS_W'(need);
                                        n_state      = S_FETCH;
                                    end
                                end
                            end
                            KIND_ALIGN: begin
                                if (r_pos >= LBR_POS_W'(align_k)) begin
                                    n_pos = r_pos - LBR_POS_W'(align_k);
                                    n_buf = '0;
                                    n_bb  = '0;
                                end else begin
                                    // ran out of bytes to rewind at position zero
                                    n_bb  = r_bb - (6'(r_pos[1:0]) << 3);
                                    n_pos = '0;
                                    n_err = 1'b1;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                    n_res.error    = n_err;
                    n_res.position = n_pos;
                end
            end

            S_FETCH: begin
                o_raddr = AW'(r_addr);
                if (r_issue_left != 3'd0) begin
                    o_re         = 1'b1;
                    n_pend       = 1'b1;
                    n_addr       = r_addr + 1'b1;
                    n_issue_left = r_issue_left - 3'd1;
                end
                if (r_pend) begin
                    n_acc     = r_acc | (32'(i_rdata) << r_sh);
                    n_sh      = r_sh + 6'd8;
                    n_rx_left = r_rx_left - 3'd1;
                    if (r_rx_left == 3'd1) begin
                        n_state = S_FINISH;
                    end
                end
            end

            S_FINISH: begin
                n_res_valid    = 1'b1;
                n_res.error    = r_err;
                n_res.position = r_pos;
                if (r_kind == KIND_U16 || r_kind == KIND_U32) begin
                    n_res.value = r_acc;
                end else begin
                    n_buf = r_acc >> r_n;
                    n_bb  = r_sh - 6'(r_n);
                    n_res.value = (r_kind == KIND_BITS_BASE) ? (r_base + take_v) : take_v;
                end
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pos        <= '0;
            r_buf        <= '0;
            r_bb         <= '0;
            r_err        <= 1'b0;
            r_issue_left <= '0;
            r_rx_left    <= '0;
            r_pend       <= 1'b0;
            r_res_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pos        <= n_pos;
            r_buf        <= n_buf;
            r_bb         <= n_bb;
            r_err        <= n_err;
            r_issue_left <= n_issue_left;
            r_rx_left    <= n_rx_left;
            r_pend       <= n_pend;
            r_res_valid  <= n_res_valid;
        end
        r_kind <= n_kind;
        r_n    <= n_n;
        r_base <= n_base;
        r_acc  <= n_acc;
        r_sh   <= n_sh;
        r_addr <= n_addr;
        r_res  <= n_res;
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

`ifndef SYNTHESIS
    // fetch engine always has a read in flight or one left to issue
    a_fetch_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FETCH) |-> (r_pend || (r_issue_left != 3'd0)))
        else $error("fetch engine stalled");

    // bit buffer never holds more than 31 bits
    a_bb_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bb <= 6'd31)
        else $error("bit buffer count out of range");

    // an error result carries a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.error) |-> (o_res.value == 32'd0))
        else $error("nonzero value with error");

    // loads only while idle, never alongside a read
    a_no_rw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_we && o_re))
        else $error("store write and read in same cycle");

    // a multi-cycle request ends with exactly one result strobe
    a_finish_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH) |=> (o_res_valid && (r_state == S_IDLE)))
        else $error("missing result after finish");
`endif

endmodule

// ----- src/lsb_first_bit_reader_core.sv -----
// lsb_first_bit_reader_core: top level of the LSB-first bit reader.
// Holds the stream size register; instantiates lbr_ctrl and lbr_store. Uses lbr_pkg.
`timescale 1ns / 1ps

// Bounds-checked LSB-first reader over a single-port-per-direction byte store.
// A request is taken when i_start is high and o_busy is low; its result shows
// on o_res for exactly one cycle with o_res_valid high, and there is no way to
// hold it off, so the receiver must take it in that cycle. Load, restart, seek,
// skip, read_bytes, align, an overrunning word or bit read, and any request
// made while the sticky error is set answer in the cycle after acceptance and
// leave o_busy low, so another request may follow at once. Word reads and bit
// reads that need a refill go through the store one byte per cycle (one read
// port, registered read data): a request fetching B bytes (B = 2 or 4 for
// u16/u32, 1..3 for a bit refill) keeps o_busy high through states S_FETCH and
// S_FINISH; a bit read served from the buffer skips S_FETCH. The stream size
// register is written through the cfg channel, which is always ready; write it
// only while no request is in flight. It saturates at STORE_BYTES. Once an
// overrun sets the error flag every request except load and restart returns
// value zero and changes nothing until a restart. The store has no reset:
// reading bytes that were never loaded gives undefined data.

module lsb_first_bit_reader_core
    import lbr_pkg::*;
#(
    parameter int STORE_BYTES = LBR_STORE_BYTES,
    parameter int MAX_BITS    = LBR_MAX_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 i_start,
    input  t_req                 i_req,
    output logic                 o_busy,
    // result strobe
    output logic                 o_res_valid,
    output t_res                 o_res,
    // stream size write
    input  logic                 i_cfg_valid,
    input  logic [LBR_POS_W-1:0] i_cfg_data,
    output logic                 o_cfg_ready
);

    localparam int AW = $clog2(STORE_BYTES);

    logic [LBR_POS_W-1:0] r_stream_size, n_stream_size;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;

    assign o_cfg_ready = 1'b1;

    // saturate the stream size at the store depth
    always_comb begin
        n_stream_size = r_stream_size;
        if (i_cfg_valid) begin
            if (32'(i_cfg_data) > 32'(STORE_BYTES)) begin
                n_stream_size = LBR_POS_W'(STORE_BYTES);
            end else begin
                n_stream_size = i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream_size <= '0;
        end else begin
            r_stream_size <= n_stream_size;
        end
    end

    lbr_ctrl #(
        .STORE_BYTES (STORE_BYTES),
        .MAX_BITS    (MAX_BITS),
        .AW          (AW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .i_req         (i_req),
        .i_stream_size (r_stream_size),
        .i_rdata       (mem_rdata),
        .o_busy        (o_busy),
        .o_res_valid   (o_res_valid),
        .o_res         (o_res),
        .o_we          (mem_we),
        .o_waddr       (mem_waddr),
        .o_wdata       (mem_wdata),
        .o_re          (mem_re),
        .o_raddr       (mem_raddr)
    );

    lbr_store #(
        .STORE_BYTES (STORE_BYTES),
        .AW          (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule
